FILE: sv/assert_macros.svh
// assertion macros used by the checker file imab_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequence is checked in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/imab_pkg.sv
// package for the interval moving average bank
// shared types and constants, no dependencies
`timescale 1ns / 1ps
package imab_pkg;
   localparam int TsW  = 32;
   localparam int SumW = 38;
   localparam int FillW = 6;
   localparam int DivW = 38;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_LAP   = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_CALC, ST_RING, ST_SUM, ST_DIV1,
      ST_DIV2, ST_WRITE, ST_OUT
   } state_type;

   typedef struct packed {
      logic          start;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;
endpackage

FILE: sv/interval_moving_average_bank.sv
// interval moving average bank, top level
// requests: tdata {now_ticks, channel, func}; responses: tdata {sample_count,
// rate_x16, avg_interval, bad_channel}. csr channel writes ticks_per_second.
// one request at a time: the addressed channel is read from the state rams,
// modified and written back. a stop or lap runs two serial 38-bit divisions
// (average, then rate; the rate division is skipped and the rate saturated
// when the average is zero) before its response is loaded. bad-channel
// requests skip the update and go straight to the response.
// the response is held in an output register until rsp_tready. the next
// request is taken once the response is loaded; if the earlier response is
// still waiting, the new one waits in the last state until it is accepted.
// reset clears control state and sweeps every entry of the per-channel ram
// before requests are taken; csr writes are taken at all times outside reset.
// the interval ring is not cleared: entries are read only once written.
// depends on imab_pkg, imab_ram, imab_div
`timescale 1ns / 1ps
module interval_moving_average_bank import imab_pkg::*; #(
   parameter int CHANNELS = 64,
   parameter int WINDOW   = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] func, [7:2] channel, [39:8] now_ticks
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] bad_channel, [32:1] avg_interval, [64:33] rate_x16, [70:65] sample_count
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RingD = CHANNELS * WINDOW;
   localparam int RingW = $clog2(RingD + 1);
   localparam int ChanW = TsW + FillW + FillW + SumW + TsW + TsW;

   typedef struct packed {
      logic [TsW-1:0]   stamp;
      logic [FillW-1:0] head;
      logic [FillW-1:0] fill;
      logic [SumW-1:0]  sum;
      logic [TsW-1:0]   avg;
      logic [TsW-1:0]   rate;
   } chan_type;

   state_type        state_ff, state_in;
   logic [31:0]      tps_ff;
   logic             clr_ff;
   logic [ChW:0]     clr_cnt_ff;
   logic [1:0]       func_ff;
   logic [5:0]       chan_ff;
   logic [TsW-1:0]   now_ff;
   chan_type         cur_ff, cur_in;
   logic [TsW-1:0]   d_ff, d_in;
   logic [RingW-1:0] slot_ff, slot_in;
   logic [71:0]      rsp_ff;
   logic             rspv_ff, rspv_in;
   logic [71:0]      rsp_in;

   logic             ch_wr;
   logic [ChW-1:0]   ch_waddr;
   chan_type         ch_wdata, ch_rdata;
   logic [ChanW-1:0] ch_rraw;
   logic             rg_wr;
   logic [TsW-1:0]   rg_rdata;
   div_req_type      dreq;
   div_rsp_type      drsp;
   logic             bad;
   logic             take;

   imab_ram #(.WIDTH(ChanW), .DEPTH(CHANNELS)) u_chan (
      .clock, .wr_en(ch_wr), .wr_addr(ch_waddr), .wr_data(ch_wdata),
      .rd_addr(chan_ff[ChW-1:0]), .rd_data(ch_rraw));
   assign ch_rdata = chan_type'(ch_rraw);

   imab_ram #(.WIDTH(TsW), .DEPTH(RingD)) u_ring (
      .clock, .wr_en(rg_wr), .wr_addr(slot_ff[$clog2(RingD)-1:0]),
      .wr_data(d_ff), .rd_addr(slot_ff[$clog2(RingD)-1:0]), .rd_data(rg_rdata));

   imab_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !clr_ff;
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = rsp_ff;
   assign bad        = 32'(chan_ff) >= 32'(CHANNELS);
   assign rg_wr      = (state_ff == ST_SUM);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      d_in     = d_ff;
      slot_in  = slot_ff;
      rspv_in  = rspv_ff;
      rsp_in   = rsp_ff;
      dreq     = '0;
      ch_wr    = clr_ff;
      ch_waddr = clr_cnt_ff[ChW-1:0];
      ch_wdata = '0;
      if (rspv_ff && rsp_tready) begin
         rspv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = bad ? ST_OUT : ST_CALC;
         end
         ST_CALC: begin
            cur_in  = ch_rdata;
            d_in    = now_ff - ch_rdata.stamp;
            slot_in = RingW'(32'(chan_ff) * WINDOW + 32'(ch_rdata.head));
            if (func_ff == FUNC_STOP || func_ff == FUNC_LAP) begin
               state_in = ST_RING;
            end else begin
               if (func_ff == FUNC_START) begin
                  cur_in.stamp = now_ff;
               end
               state_in = ST_WRITE;
            end
         end
         ST_RING: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (32'(cur_ff.fill) >= 32'(WINDOW)) begin
               cur_in.sum = cur_ff.sum - SumW'(rg_rdata) + SumW'(d_ff);
            end else begin
               cur_in.sum  = cur_ff.sum + SumW'(d_ff);
               cur_in.fill = cur_ff.fill + 1'b1;
            end
            if (32'(cur_ff.head) + 1 >= 32'(WINDOW)) begin
               cur_in.head = '0;
            end else begin
               cur_in.head = cur_ff.head + 1'b1;
            end
            if (func_ff == FUNC_LAP) begin
               cur_in.stamp = now_ff;
            end
            state_in = ST_DIV1;
            dreq.start    = 1'b1;
            dreq.dividend = cur_in.sum;
            dreq.divisor  = DivW'(cur_in.fill);
         end
         ST_DIV1: begin
            if (drsp.done) begin
               cur_in.avg = drsp.quotient[TsW-1:0];
               if (drsp.quotient[TsW-1:0] == '0) begin
                  cur_in.rate = '1;
                  state_in    = ST_WRITE;
               end else begin
                  dreq.start    = 1'b1;
                  dreq.dividend = {2'b00, tps_ff, 4'b0000};
                  dreq.divisor  = DivW'(drsp.quotient[TsW-1:0]);
                  state_in      = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (drsp.done) begin
               cur_in.rate = (drsp.quotient[DivW-1:TsW] != '0) ? '1
                                                              : drsp.quotient[TsW-1:0];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ch_wr    = 1'b1;
            ch_waddr = chan_ff[ChW-1:0];
            ch_wdata = cur_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rspv_ff || rsp_tready) begin
               rspv_in = 1'b1;
               if (bad) begin
                  rsp_in = 72'd1;
               end else begin
                  rsp_in = {1'b0, cur_ff.fill, cur_ff.rate, cur_ff.avg, 1'b0};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tps_ff     <= 32'd1000000;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         rspv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         if (csr_valid) begin
            tps_ff <= csr_data;
         end
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (32'(clr_cnt_ff) == CHANNELS - 1) begin
               clr_ff <= 1'b0;
            end
         end
      end
      if (take) begin
         func_ff <= req_tdata[1:0];
         chan_ff <= req_tdata[7:2];
         now_ff  <= req_tdata[39:8];
      end
      cur_ff  <= cur_in;
      d_ff    <= d_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end
endmodule

FILE: sv/imab_ram.sv
// generic single-port-write, single-read synchronous ram
// registered read data, no dependencies
`timescale 1ns / 1ps
module imab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/imab_div.sv
// radix-4 restoring divider, two quotient bits per cycle
// uses imab_pkg
`timescale 1ns / 1ps
module imab_div import imab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int Steps = DivW / 2;
   localparam int CntW  = $clog2(Steps + 1);

   logic [DivW-1:0] quo_ff, quo_in;
   logic [DivW:0]   rem_ff, rem_in;
   logic [DivW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW:0]   sh_a;
   logic [DivW:0]   dif_a;
   logic            bit_a;
   logic [DivW-1:0] rem_a;
   logic [DivW:0]   sh_b;
   logic [DivW:0]   dif_b;
   logic            bit_b;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh_a    = {rem_ff[DivW-1:0], quo_ff[DivW-1]};
      dif_a   = sh_a - {1'b0, den_ff};
      bit_a   = !dif_a[DivW];
      rem_a   = bit_a ? dif_a[DivW-1:0] : sh_a[DivW-1:0];
      sh_b    = {rem_a, quo_ff[DivW-2]};
      dif_b   = sh_b - {1'b0, den_ff};
      bit_b   = !dif_b[DivW];
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = CntW'(Steps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = bit_b ? dif_b : sh_b;
         quo_in = {quo_ff[DivW-3:0], bit_a, bit_b};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

FILE: sv/imab_checker.sv
// port-level checker for the interval moving average bank
// uses assert_macros.svh, bound to interval_moving_average_bank
`timescale 1ns / 1ps
`include "assert_macros.svh"
module imab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   logic req_take;
   logic rsp_wait;
   logic bad_rsp;

   assign req_take = req_tvalid && req_tready;
   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign bad_rsp  = rsp_tvalid && rsp_tdata[0];

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata), "rsp not held")
   `CHK_NEXT(a_one_req, clock, reset, req_take, !req_tready, "second request taken while busy")
   `CHK_IMPL(a_bad_zero, clock, reset, bad_rsp, rsp_tdata[71:1] == '0, "bad rsp not zero")
   `CHK_IMPL(a_rsp_known, clock, reset, rsp_tvalid, !$isunknown(rsp_tdata), "rsp has x bits")
endmodule

bind interval_moving_average_bank imab_checker u_imab_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);
